### design/bat_pkg.sv
// Shared constants, command and status types for the buddy allocator tree.
package bat_pkg;

  // Pool geometry. The pool is TOTAL_BLOCKS rounded up to a power of two.
  localparam int TOTAL_BLOCKS = 1024;
  localparam int BLOCK_BYTES  = 4096;
  localparam int POOL_LOG     = $clog2(TOTAL_BLOCKS);
  localparam int POOL         = 1 << POOL_LOG;
  localparam int DEPTH        = 2 * POOL;

  // Node addresses and node values (largest free run in blocks).
  localparam int NODE_W = POOL_LOG + 1;
  localparam int VAL_W  = POOL_LOG + 1;
  localparam int LVL_W  = $clog2(POOL_LOG + 1);

  // Field widths at the ports.
  localparam int REQ_W   = 23;
  localparam int OFF_W   = 22;
  localparam int BYTES_W = 23;

  // Width for byte-size compares and for the granted byte offset.
  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int CMP_W = (BB_W + POOL_LOG > REQ_W) ? BB_W + POOL_LOG : REQ_W;
  localparam int OB_W  = (BB_W + POOL_LOG > OFF_W) ? BB_W + POOL_LOG : OFF_W;

  // Offset divided by BLOCK_BYTES through a rounded-up reciprocal, exact for
  // every offset below 2**OFF_W.
  localparam int DIV_SH  = OFF_W + $clog2(BLOCK_BYTES);
  localparam longint unsigned RECIP =
      ((64'd1 << DIV_SH) + longint'(BLOCK_BYTES) - 64'd1) / longint'(BLOCK_BYTES);
  localparam int RECIP_W = OFF_W + 1;
  localparam int PROD_W  = OFF_W + RECIP_W;

  // Operation codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Read address selection for the two tree read ports.
  localparam logic [1:0] RD_NODE  = 2'd0;
  localparam logic [1:0] RD_CHILD = 2'd1;
  localparam logic [1:0] RD_UP    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       prep;
    logic       dsc_step;
    logic       mark;
    logic       asc_write;
    logic       set_fail;
    logic [1:0] rd_sel;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic req_ok;
    logic is_free;
    logic root_fit;
    logic node_zero;
    logic root_last;
    logic desc_last;
    logic at_root;
    logic up_stop;
    logic parent_root;
  } dp_stat_t;

endpackage

### design/bat_ram.sv
// Generic RAM with one write port and two registered read ports.
module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/bat_ctrl.sv
// Controller state machine that sequences the clear pass, descent and ascent.
module bat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bat_pkg::dp_stat_t st,
  output bat_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import bat_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_PREP     = 4'd2;
  localparam logic [3:0] S_NODE_RD  = 4'd3;
  localparam logic [3:0] S_NODE_CHK = 4'd4;
  localparam logic [3:0] S_DSC_RD   = 4'd5;
  localparam logic [3:0] S_DSC_CMP  = 4'd6;
  localparam logic [3:0] S_MARK     = 4'd7;
  localparam logic [3:0] S_ASC_RD   = 4'd8;
  localparam logic [3:0] S_ASC_CMP  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register; reset starts the clearing pass over the tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_NODE;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_NODE_RD;
      end
      S_NODE_RD: begin
        if (st.req_ok) begin
          state_next = S_NODE_CHK;
        end else begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_NODE_CHK: begin
        if (st.is_free) begin
          state_next = st.node_zero ? S_MARK : S_DONE;
        end else if (!st.root_fit) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end else if (st.root_last) begin
          state_next = S_MARK;
        end else begin
          state_next = S_DSC_RD;
        end
      end
      S_DSC_RD: begin
        cmd.rd_sel = RD_CHILD;
        state_next = S_DSC_CMP;
      end
      S_DSC_CMP: begin
        cmd.dsc_step = 1'b1;
        state_next   = st.desc_last ? S_MARK : S_DSC_RD;
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = st.at_root ? S_DONE : S_ASC_RD;
      end
      S_ASC_RD: begin
        cmd.rd_sel = RD_UP;
        state_next = S_ASC_CMP;
      end
      S_ASC_CMP: begin
        if (st.up_stop) begin
          state_next = S_DONE;
        end else begin
          cmd.asc_write = 1'b1;
          state_next    = st.parent_root ? S_DONE : S_ASC_RD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // The result beat lasts one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  // An accepted item always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // The ascent never starts from the root node.
  a_asc_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_ASC_RD) |-> !st.at_root)
    else $error("ascent started at the root");

endmodule

### design/bat_dpath.sv
// Datapath: request rounding, node index arithmetic and the tree memory.
module bat_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  bat_pkg::ctl_cmd_t           cmd,
  output bat_pkg::dp_stat_t           st,
  input  logic                        command,
  input  logic [bat_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bat_pkg::OFF_W-1:0]   free_offset,
  input  logic [bat_pkg::REQ_W-1:0]   free_size,
  output logic                        status,
  output logic [bat_pkg::OFF_W-1:0]   granted_offset,
  output logic [bat_pkg::BYTES_W-1:0] granted_bytes
);
  import bat_pkg::*;

  // Item registers.
  logic                is_free;
  logic [LVL_W-1:0]    k;
  logic                fits;
  logic [OFF_W-1:0]    q;
  logic                req_ok;
  logic                fail;
  logic [NODE_W-1:0]   i;
  logic [LVL_W-1:0]    s_log;
  logic [POOL_LOG-1:0] blk_off;
  logic [LVL_W-1:0]    fs_log;
  logic [VAL_W-1:0]    cur;

  // Clearing pass registers.
  logic [NODE_W-1:0] clr_idx;
  logic [VAL_W-1:0]  clr_val;

  // Tree memory ports.
  logic              we;
  logic [NODE_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [NODE_W-1:0] raddr_a;
  logic [NODE_W-1:0] raddr_b;
  logic [VAL_W-1:0]  rdata_a;
  logic [VAL_W-1:0]  rdata_b;

  bat_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Round the byte count up to a power-of-two number of blocks.
  logic [CMP_W-1:0] bytes_ext;
  logic [LVL_W-1:0] rnd_k;
  logic             rnd_fit;

  always_comb begin
    bytes_ext = command ? CMP_W'(free_size) : CMP_W'(request_bytes);
    rnd_k     = LVL_W'(POOL_LOG);
    for (int n = POOL_LOG; n >= 0; n--) begin
      if ((CMP_W'(BLOCK_BYTES) << n) >= bytes_ext) begin
        rnd_k = LVL_W'(n);
      end
    end
    rnd_fit = (CMP_W'(BLOCK_BYTES) << POOL_LOG) >= bytes_ext;
  end

  // Offset in blocks, by multiplying with the reciprocal of the block size.
  logic [PROD_W-1:0] div_prod;
  logic [PROD_W-1:0] div_shift;

  assign div_prod  = PROD_W'(free_offset) * PROD_W'(RECIP);
  assign div_shift = div_prod >> DIV_SH;

  // Node index of the buffer being freed, from its level and position.
  logic [OFF_W-1:0]  idx;
  logic [OFF_W-1:0]  lvl_count;
  logic              idx_ok;
  logic [LVL_W-1:0]  depth_lvl;
  logic [NODE_W-1:0] first;
  logic [NODE_W-1:0] free_node;

  assign idx       = q >> k;
  assign lvl_count = OFF_W'(POOL) >> k;
  assign idx_ok    = idx < lvl_count;
  assign depth_lvl = LVL_W'(POOL_LOG) - k;
  assign first     = (NODE_W'(1) << depth_lvl) - NODE_W'(1);
  assign free_node = first + idx[NODE_W-1:0];

  // Tree neighbors of the current node.
  logic [VAL_W-1:0]  need;
  logic [VAL_W-1:0]  fsv;
  logic [NODE_W-1:0] left;
  logic [NODE_W-1:0] buddy;
  logic [NODE_W-1:0] parent;

  assign need   = VAL_W'(1) << k;
  assign fsv    = VAL_W'(1) << fs_log;
  assign left   = {i[NODE_W-2:0], 1'b1};
  assign buddy  = i[0] ? i + NODE_W'(1) : i - NODE_W'(1);
  assign parent = (i - NODE_W'(1)) >> 1;

  // Descent choice: left when the right does not fit, or when the left fits and is no larger than the right.
  logic go_left;

  assign go_left = (rdata_b < need) || ((rdata_a >= need) && (rdata_a <= rdata_b));

  // New parent value on the ascent; two wholly free buddies merge on a free.
  logic [VAL_W-1:0] up_max;
  logic [VAL_W-1:0] up_val;

  always_comb begin
    up_max = (cur > rdata_a) ? cur : rdata_a;
    up_val = up_max;
    if (is_free && (cur == fsv) && (rdata_a == fsv)) begin
      up_val = fsv << 1;
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_NODE: begin
        raddr_a = i;
        raddr_b = i;
      end
      RD_CHILD: begin
        raddr_a = left;
        raddr_b = left + NODE_W'(1);
      end
      RD_UP: begin
        raddr_a = buddy;
        raddr_b = parent;
      end
      default: begin
        raddr_a = '0;
        raddr_b = '0;
      end
    endcase
  end

  // Write port selection.
  always_comb begin
    we    = cmd.clr_step || cmd.mark || cmd.asc_write;
    waddr = i;
    wdata = is_free ? need : '0;
    if (cmd.clr_step) begin
      waddr = clr_idx;
      wdata = clr_val;
    end else if (cmd.asc_write) begin
      waddr = parent;
      wdata = up_val;
    end
  end

  // Clearing pass: each level's size halves after its last node.
  logic [NODE_W:0] clr_plus2;
  logic            clr_lvl_end;

  assign clr_plus2   = {1'b0, clr_idx} + (NODE_W + 1)'(2);
  assign clr_lvl_end = (clr_plus2 & (clr_plus2 - (NODE_W + 1)'(1))) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      clr_val <= VAL_W'(POOL);
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + NODE_W'(1);
      if (clr_lvl_end) begin
        clr_val <= clr_val >> 1;
      end
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free <= (command == CMD_FREE);
      k       <= rnd_k;
      fits    <= rnd_fit;
      q       <= div_shift[OFF_W-1:0];
      fail    <= 1'b0;
    end
    if (cmd.prep) begin
      i       <= is_free ? free_node : '0;
      s_log   <= LVL_W'(POOL_LOG);
      blk_off <= '0;
      fs_log  <= k;
      req_ok  <= fits && (!is_free || idx_ok);
    end
    if (cmd.set_fail) begin
      fail <= 1'b1;
    end
    if (cmd.dsc_step) begin
      i     <= go_left ? left : left + NODE_W'(1);
      s_log <= s_log - LVL_W'(1);
      if (!go_left) begin
        blk_off <= blk_off + (POOL_LOG'(1) << (s_log - LVL_W'(1)));
      end
    end
    if (cmd.mark) begin
      cur <= is_free ? need : '0;
    end
    if (cmd.asc_write) begin
      i      <= parent;
      cur    <= up_val;
      fs_log <= fs_log + LVL_W'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    st.clr_last    = (clr_idx == NODE_W'(DEPTH - 2));
    st.req_ok      = req_ok;
    st.is_free     = is_free;
    st.root_fit    = (rdata_a >= need);
    st.node_zero   = (rdata_a == '0);
    st.root_last   = (s_log == k);
    st.desc_last   = (s_log == k + LVL_W'(1));
    st.at_root     = (i == '0);
    st.up_stop     = (rdata_b == up_val);
    st.parent_root = (parent == '0);
  end

  // Result fields; zero for a free and for a failed allocation.
  logic [OB_W-1:0]  off_bytes;
  logic [CMP_W-1:0] size_bytes;
  logic             no_grant;

  assign off_bytes  = OB_W'(blk_off) * OB_W'(BLOCK_BYTES);
  assign size_bytes = CMP_W'(BLOCK_BYTES) << k;
  assign no_grant   = fail || is_free;

  assign status         = fail && !is_free;
  assign granted_offset = no_grant ? '0 : off_bytes[OFF_W-1:0];
  assign granted_bytes  = no_grant ? '0 : size_bytes[BYTES_W-1:0];

endmodule

### design/buddy_allocator_tree_core.sv
// Top level of the binary buddy allocator: controller plus datapath.
//
// Usage: an item is one beat on the command channel, taken at a rising edge
// where start is high and busy is low. command selects allocate or free;
// allocate uses request_bytes, free uses free_offset and free_size.
// Every item gives exactly one result beat: done is high for one cycle with
// status, granted_offset and granted_bytes valid in that same cycle.
// The receiver cannot stall; it must take the beat when done is high.
// A completed walk reads the tree memory once per level walked down and once
// per level walked up, with a registered read before each compare. At 1024
// blocks a one-block allocation walks down all 10 levels below the root. A
// request rejected before the walk goes straight to the result beat. Items
// are handled one at a time and the next one is taken at the earliest in the
// cycle after the result beat.
// After reset the block writes every node of the 2047-node tree once, one
// node a cycle; busy stays high until that pass ends.
module buddy_allocator_tree_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        command,
  input  logic [bat_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bat_pkg::OFF_W-1:0]   free_offset,
  input  logic [bat_pkg::REQ_W-1:0]   free_size,
  output logic                        busy,
  output logic                        done,
  output logic                        status,
  output logic [bat_pkg::OFF_W-1:0]   granted_offset,
  output logic [bat_pkg::BYTES_W-1:0] granted_bytes
);
  import bat_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  bat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bat_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .command        (command),
    .request_bytes  (request_bytes),
    .free_offset    (free_offset),
    .free_size      (free_size),
    .status         (status),
    .granted_offset (granted_offset),
    .granted_bytes  (granted_bytes)
  );

endmodule
